/* rtl/keyed_ring_table_upsert_lookup_defines.svh */
// ---------------------------------------------------------------------------
// Keyed ring table assertion macros
// Shared helpers for concurrent checks, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef KEYED_RING_TABLE_UPSERT_LOOKUP_DEFINES_SVH
`define KEYED_RING_TABLE_UPSERT_LOOKUP_DEFINES_SVH

// Implication checked at every edge out of reset
`define KRT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/krt_pkg.sv */
// ---------------------------------------------------------------------------
// krt_pkg
// Types and codes shared by the keyed ring table modules.
// ---------------------------------------------------------------------------
package krt_pkg;

    typedef enum logic {
        OP_UPSERT = 1'b0,
        OP_FIND   = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_MISS     = 3'd0,
        ST_HIT      = 3'd1,
        ST_REPLACED = 3'd2,
        ST_APPENDED = 3'd3,
        ST_EVICTED  = 3'd4
    } t_status;

    // Identity key of one record
    typedef struct packed {
        logic [63:0] time_volume;
        logic [63:0] target_pulses;
        logic [63:0] reject_dur_mode_res;
        logic [7:0]  preset;
    } t_key;

    // Payload of one record
    typedef struct packed {
        logic [31:0] rate_bits;
        logic [31:0] scheme_id;
        logic [31:0] scheme_revision;
        logic [31:0] startup_pulses;
        logic [31:0] startup_volume;
        logic [31:0] stable_rate;
    } t_payload;

endpackage

/* rtl/krt_ifs.sv */
// ---------------------------------------------------------------------------
// Keyed ring table channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface krt_req_if import krt_pkg::*; ();
    logic        valid;
    logic        ready;
    t_opcode     opcode;
    logic [63:0] in_time_volume;
    logic [63:0] in_target_pulses;
    logic [63:0] in_reject_dur_mode_res;
    logic [7:0]  in_preset;
    logic [31:0] in_rate_bits;
    logic [31:0] in_scheme_id;
    logic [31:0] in_scheme_revision;
    logic [31:0] in_startup_pulses;
    logic [31:0] in_startup_volume;
    logic [31:0] in_stable_rate;

    modport source (
        output valid, opcode, in_time_volume, in_target_pulses, in_reject_dur_mode_res,
               in_preset, in_rate_bits, in_scheme_id, in_scheme_revision,
               in_startup_pulses, in_startup_volume, in_stable_rate,
        input  ready
    );
    modport sink (
        input  valid, opcode, in_time_volume, in_target_pulses, in_reject_dur_mode_res,
               in_preset, in_rate_bits, in_scheme_id, in_scheme_revision,
               in_startup_pulses, in_startup_volume, in_stable_rate,
        output ready
    );
endinterface

interface krt_rsp_if import krt_pkg::*; #(parameter int DEPTH = 64) ();
    localparam int CW = $clog2(DEPTH + 1);

    logic          valid;
    logic          ready;
    t_status       status;
    logic [CW-1:0] entry_count;
    logic [63:0]   out_time_volume;
    logic [63:0]   out_target_pulses;
    logic [63:0]   out_reject_dur_mode_res;
    logic [7:0]    out_preset;
    logic [31:0]   out_rate_bits;
    logic [31:0]   out_scheme_id;
    logic [31:0]   out_scheme_revision;
    logic [31:0]   out_startup_pulses;
    logic [31:0]   out_startup_volume;
    logic [31:0]   out_stable_rate;

    modport source (
        output valid, status, entry_count, out_time_volume, out_target_pulses,
               out_reject_dur_mode_res, out_preset, out_rate_bits, out_scheme_id,
               out_scheme_revision, out_startup_pulses, out_startup_volume,
               out_stable_rate,
        input  ready
    );
    modport sink (
        input  valid, status, entry_count, out_time_volume, out_target_pulses,
               out_reject_dur_mode_res, out_preset, out_rate_bits, out_scheme_id,
               out_scheme_revision, out_startup_pulses, out_startup_volume,
               out_stable_rate,
        output ready
    );
endinterface

/* rtl/krt_store.sv */
// ---------------------------------------------------------------------------
// krt_store
// Record memories: one read port and one write port, registered read data.
// ---------------------------------------------------------------------------
module krt_store import krt_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_key          o_rd_key,
    output t_payload      o_rd_pay,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_key          i_wr_key,
    input  t_payload      i_wr_pay
);

    t_key     r_key_mem [DEPTH];
    t_payload r_pay_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_pay_mem[i_wr_addr] <= i_wr_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key <= r_key_mem[i_rd_addr];
            o_rd_pay <= r_pay_mem[i_rd_addr];
        end
    end

endmodule

/* rtl/krt_ctrl.sv */
// ---------------------------------------------------------------------------
// krt_ctrl
// Search sequencer: walks the ring newest to oldest, then commits the result.
// ---------------------------------------------------------------------------
module krt_ctrl import krt_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    krt_req_if.sink       i_req,
    krt_rsp_if.source     o_rsp,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_key          i_rd_key,
    input  t_payload      i_rd_pay,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_key          o_wr_key,
    output t_payload      o_wr_pay
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
        return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
    endfunction

    t_state        r_state;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_left;
    logic [AW-1:0] r_rd_slot;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_slot;
    t_opcode       r_op;
    t_key          r_key;
    t_payload      r_pay;
    logic          r_hit;
    logic [AW-1:0] r_hit_slot;
    t_key          r_found_key;
    t_payload      r_found_pay;

    logic          r_out_vld;
    t_status       r_out_status;
    logic [CW-1:0] r_out_count;
    t_key          r_out_key;
    t_payload      r_out_pay;

    logic          w_full;
    logic          w_hit;
    logic          w_finish;
    logic          w_commit;
    t_status       n_status;
    logic [CW-1:0] n_count;

    assign w_full   = (r_count == CW'(DEPTH));
    assign w_hit    = (r_state == S_SEARCH) && r_cmp_vld && (i_rd_key == r_key);
    assign w_finish = w_hit || (r_left == '0);
    assign w_commit = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    always_comb begin
        n_count = r_count;
        if (r_op == OP_FIND) begin
            n_status = r_hit ? ST_HIT : ST_MISS;
        end else if (r_hit) begin
            n_status = ST_REPLACED;
        end else if (w_full) begin
            n_status = ST_EVICTED;
        end else begin
            n_status = ST_APPENDED;
            n_count  = r_count + CW'(1);
        end
    end

    assign o_rd_en   = (r_state == S_SEARCH) && (r_left != '0);
    assign o_rd_addr = r_rd_slot;

    // When full the tail sits on the oldest slot, so an append evicts it
    assign o_wr_en   = w_commit && (r_op == OP_UPSERT);
    assign o_wr_addr = r_hit ? r_hit_slot : r_tail;
    assign o_wr_key  = r_key;
    assign o_wr_pay  = r_pay;

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid                   = r_out_vld;
    assign o_rsp.status                  = r_out_status;
    assign o_rsp.entry_count             = r_out_count;
    assign o_rsp.out_time_volume         = r_out_key.time_volume;
    assign o_rsp.out_target_pulses       = r_out_key.target_pulses;
    assign o_rsp.out_reject_dur_mode_res = r_out_key.reject_dur_mode_res;
    assign o_rsp.out_preset              = r_out_key.preset;
    assign o_rsp.out_rate_bits           = r_out_pay.rate_bits;
    assign o_rsp.out_scheme_id           = r_out_pay.scheme_id;
    assign o_rsp.out_scheme_revision     = r_out_pay.scheme_revision;
    assign o_rsp.out_startup_pulses      = r_out_pay.startup_pulses;
    assign o_rsp.out_startup_volume      = r_out_pay.startup_volume;
    assign o_rsp.out_stable_rate         = r_out_pay.stable_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tail    <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op      <= i_req.opcode;
                        r_key     <= '{i_req.in_time_volume, i_req.in_target_pulses,
                                       i_req.in_reject_dur_mode_res, i_req.in_preset};
                        r_pay     <= '{i_req.in_rate_bits, i_req.in_scheme_id,
                                       i_req.in_scheme_revision, i_req.in_startup_pulses,
                                       i_req.in_startup_volume, i_req.in_stable_rate};
                        r_rd_slot <= slot_dec(r_tail);
                        r_left    <= r_count;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // Issue the next read while comparing the previous one
                    if (r_left != '0) begin
                        r_rd_slot  <= slot_dec(r_rd_slot);
                        r_left     <= r_left - CW'(1);
                        r_cmp_slot <= r_rd_slot;
                        r_cmp_vld  <= 1'b1;
                    end else begin
                        r_cmp_vld  <= 1'b0;
                    end
                    if (w_finish) begin
                        r_hit       <= w_hit;
                        r_hit_slot  <= r_cmp_slot;
                        r_found_key <= w_hit ? i_rd_key : '0;
                        r_found_pay <= w_hit ? i_rd_pay : '0;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (w_commit) begin
                        r_out_status <= n_status;
                        r_out_count  <= n_count;
                        r_out_key    <= (r_op == OP_FIND) ? r_found_key : '0;
                        r_out_pay    <= (r_op == OP_FIND) ? r_found_pay : '0;
                        r_count      <= n_count;
                        if (r_op == OP_UPSERT && !r_hit) begin
                            r_tail <= slot_inc(r_tail);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/keyed_ring_table_upsert_lookup.sv */
// ---------------------------------------------------------------------------
// keyed_ring_table_upsert_lookup
// Ring of DEPTH keyed records with upsert and newest-first lookup.
// ---------------------------------------------------------------------------
//  channel  direction  handshake         carries
//  i_req    in         valid / ready     opcode, key fields, payload fields
//  o_rsp    out        valid / ready     status, entry_count, found record
//
// o_rsp.valid rises when the result is committed: after the search has compared
// all N records held before acceptance, or sooner when a match turns up early,
// and once the output register is free. i_req.ready returns with that commit.
// One key is compared per cycle, set by the single read port of the key memory.
// One transaction is in flight at a time; a finished result waits in the
// output register, and a stalled o_rsp holds the next commit back.
// Reset clears count, ring pointer, state and output valid; record memories are not cleared.
// ---------------------------------------------------------------------------
module keyed_ring_table_upsert_lookup import krt_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    krt_req_if.sink   i_req,
    krt_rsp_if.source o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_key          w_rd_key;
    t_payload      w_rd_pay;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_key          w_wr_key;
    t_payload      w_wr_pay;

    krt_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_key  (w_rd_key),
        .i_rd_pay  (w_rd_pay),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_key  (w_wr_key),
        .o_wr_pay  (w_wr_pay)
    );

    krt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_key  (w_rd_key),
        .o_rd_pay  (w_rd_pay),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_key  (w_wr_key),
        .i_wr_pay  (w_wr_pay)
    );

endmodule

/* rtl/krt_checker.sv */
// ---------------------------------------------------------------------------
// krt_checker
// Port-level checks on result codes, counts and zeroed record fields.
// ---------------------------------------------------------------------------
`include "keyed_ring_table_upsert_lookup_defines.svh"

module krt_checker import krt_pkg::*; #(
    parameter int DEPTH = 64
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input t_status                     i_status,
    input logic [$clog2(DEPTH+1)-1:0]  i_count,
    input logic [63:0]                 i_time_volume,
    input logic [31:0]                 i_stable_rate
);

    localparam int CW = $clog2(DEPTH + 1);

    logic w_upsert_rsp;
    logic w_miss_rsp;
    logic w_evict_rsp;
    logic w_other_rsp;
    logic w_blank;
    logic w_full;
    logic w_quiet_accept;

    assign w_upsert_rsp   = i_out_valid && (i_status == ST_REPLACED ||
                            i_status == ST_APPENDED || i_status == ST_EVICTED);
    assign w_miss_rsp     = i_out_valid && (i_status == ST_MISS);
    assign w_evict_rsp    = i_out_valid && (i_status == ST_EVICTED);
    assign w_other_rsp    = i_out_valid && (i_status != ST_MISS);
    assign w_blank        = (i_time_volume == '0) && (i_stable_rate == '0);
    assign w_full         = (i_count == CW'(DEPTH));
    assign w_quiet_accept = i_in_valid && i_in_ready && !i_out_valid;

    `KRT_ASSERT_IMPL(a_upsert_blank, w_upsert_rsp, w_blank, "upsert result carries data")
    `KRT_ASSERT_IMPL(a_miss_blank, w_miss_rsp, w_blank, "miss carries data")
    `KRT_ASSERT_IMPL(a_evict_full, w_evict_rsp, w_full, "evict below full")
    `KRT_ASSERT_IMPL(a_hit_nonempty, w_other_rsp, i_count != '0, "result with empty count")
    `KRT_ASSERT_NEXT(a_no_early_rsp, w_quiet_accept, !i_out_valid, "result right after request")

endmodule

bind keyed_ring_table_upsert_lookup krt_checker #(.DEPTH(DEPTH)) u_krt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_status      (o_rsp.status),
    .i_count       (o_rsp.entry_count),
    .i_time_volume (o_rsp.out_time_volume),
    .i_stable_rate (o_rsp.out_stable_rate)
);

/* test/keyed_ring_table_upsert_lookup_tb.sv */
// ---------------------------------------------------------------------------
// keyed_ring_table_upsert_lookup_tb
// Drives upsert and find transactions into the keyed ring table and checks
// every response against a local copy of the ring that is updated on each
// accepted request. Runs directed corner cases, then random traffic built
// from reused, fresh and one-bit-off keys, under four idle/stall patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyed_ring_table_upsert_lookup_tb;
    import krt_pkg::*;

    localparam int TBL_DEPTH   = 64;
    localparam int KEY_BITS    = $bits(t_key);
    localparam int PHASE_ITEMS = 485;
    localparam int KEY_MEMORY  = 96;

    typedef struct packed {
        t_opcode  op;
        t_key     key;
        t_payload pl;
    } t_ring_op;

    typedef struct packed {
        t_status     status;
        logic [6:0]  count;
        t_key        key;
        t_payload    pl;
    } t_table_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    krt_req_if                        req_if ();
    krt_rsp_if #(.DEPTH(TBL_DEPTH))   rsp_if ();

    keyed_ring_table_upsert_lookup #(.DEPTH(TBL_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Local copy of the ring
    t_key     ring_key     [TBL_DEPTH];
    t_payload ring_payload [TBL_DEPTH];
    int       ring_oldest = 0;
    int       ring_fill   = 0;

    t_ring_op      pending_ops [$];
    t_table_result due_results [$];
    t_key          known_keys  [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;

    function automatic t_table_result ring_table_apply(t_ring_op op);
        t_table_result res;
        int            s;
        int            slot;
        bit            hit;
        res  = '0;
        hit  = 1'b0;
        slot = 0;
        // Search newest to oldest; the first exact key match wins
        for (int i = 0; i < ring_fill && !hit; i++) begin
            s = (ring_oldest + ring_fill - 1 - i) % TBL_DEPTH;
            if (ring_key[s] == op.key) begin
                hit  = 1'b1;
                slot = s;
            end
        end
        if (op.op == OP_FIND) begin
            res.status = hit ? ST_HIT : ST_MISS;
            if (hit) begin
                res.key = ring_key[slot];
                res.pl  = ring_payload[slot];
            end
        end else begin
            if (hit) begin
                res.status = ST_REPLACED;
            end else if (ring_fill < TBL_DEPTH) begin
                slot = (ring_oldest + ring_fill) % TBL_DEPTH;
                ring_fill++;
                res.status = ST_APPENDED;
            end else begin
                slot = ring_oldest;
                ring_oldest = (ring_oldest + 1) % TBL_DEPTH;
                res.status = ST_EVICTED;
            end
            ring_key[slot]     = op.key;
            ring_payload[slot] = op.pl;
        end
        res.count = 7'(ring_fill);
        return res;
    endfunction

    function automatic t_ring_op make_op(t_opcode op, t_key key, t_payload pl);
        t_ring_op r;
        r.op  = op;
        r.key = key;
        r.pl  = pl;
        return r;
    endfunction

    function automatic t_payload random_payload();
        t_payload pl;
        pl.rate_bits       = $urandom;
        pl.scheme_id       = $urandom;
        pl.scheme_revision = $urandom;
        pl.startup_pulses  = $urandom;
        pl.startup_volume  = $urandom;
        pl.stable_rate     = $urandom;
        return pl;
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.time_volume         = {$urandom, $urandom};
        k.target_pulses       = {$urandom, $urandom};
        k.reject_dur_mode_res = {$urandom, $urandom};
        k.preset              = 8'($urandom_range(255));
        // Now and then pin a field to an extreme
        case ($urandom_range(9))
            0: k.time_volume         = '1;
            1: k.reject_dur_mode_res = '0;
            2: k.preset              = '1;
            3: k.target_pulses       = '0;
            default: ;
        endcase
        return k;
    endfunction

    function automatic t_ring_op random_ring_op();
        t_ring_op           r;
        logic [KEY_BITS-1:0] flat;
        int                 pick;
        int                 span;
        r.op = ($urandom_range(99) < 55) ? OP_UPSERT : OP_FIND;
        r.pl = random_payload();
        pick = $urandom_range(99);
        if (known_keys.size() == 0 || pick < 28) begin
            r.key = random_key();
        end else begin
            // Favor recent keys, but reach past the ring depth to hit evicted ones
            span  = (known_keys.size() - 1 < 80) ? known_keys.size() - 1 : 80;
            r.key = known_keys[known_keys.size() - 1 - $urandom_range(span)];
            if (pick < 42) begin
                flat = r.key;
                flat[$urandom_range(KEY_BITS - 1)] ^= 1'b1;
                r.key = flat;
            end
        end
        if (r.op == OP_UPSERT) begin
            known_keys.push_back(r.key);
            if (known_keys.size() > KEY_MEMORY)
                void'(known_keys.pop_front());
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Driver: present the next pending transaction, predict it on acceptance
    t_ring_op drv_cur;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                due_results.push_back(ring_table_apply(drv_cur));
            if (!req_if.valid || req_if.ready) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_cur = pending_ops.pop_front();
                    req_if.valid                  <= 1'b1;
                    req_if.opcode                 <= drv_cur.op;
                    req_if.in_time_volume         <= drv_cur.key.time_volume;
                    req_if.in_target_pulses       <= drv_cur.key.target_pulses;
                    req_if.in_reject_dur_mode_res <= drv_cur.key.reject_dur_mode_res;
                    req_if.in_preset              <= drv_cur.key.preset;
                    req_if.in_rate_bits           <= drv_cur.pl.rate_bits;
                    req_if.in_scheme_id           <= drv_cur.pl.scheme_id;
                    req_if.in_scheme_revision     <= drv_cur.pl.scheme_revision;
                    req_if.in_startup_pulses      <= drv_cur.pl.startup_pulses;
                    req_if.in_startup_volume      <= drv_cur.pl.startup_volume;
                    req_if.in_stable_rate         <= drv_cur.pl.stable_rate;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each response transaction with the oldest prediction
    t_table_result mon_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: response with none outstanding, status %0d count %0d",
                             $time, rsp_if.status, rsp_if.entry_count);
                    fail_count++;
                end else begin
                    mon_want = due_results.pop_front();
                    check_field("status", mon_want.status, rsp_if.status);
                    check_field("entry_count", mon_want.count, rsp_if.entry_count);
                    check_field("out_time_volume", mon_want.key.time_volume,
                                rsp_if.out_time_volume);
                    check_field("out_target_pulses", mon_want.key.target_pulses,
                                rsp_if.out_target_pulses);
                    check_field("out_reject_dur_mode_res", mon_want.key.reject_dur_mode_res,
                                rsp_if.out_reject_dur_mode_res);
                    check_field("out_preset", mon_want.key.preset, rsp_if.out_preset);
                    check_field("out_rate_bits", mon_want.pl.rate_bits,
                                rsp_if.out_rate_bits);
                    check_field("out_scheme_id", mon_want.pl.scheme_id,
                                rsp_if.out_scheme_id);
                    check_field("out_scheme_revision", mon_want.pl.scheme_revision,
                                rsp_if.out_scheme_revision);
                    check_field("out_startup_pulses", mon_want.pl.startup_pulses,
                                rsp_if.out_startup_pulses);
                    check_field("out_startup_volume", mon_want.pl.startup_volume,
                                rsp_if.out_startup_volume);
                    check_field("out_stable_rate", mon_want.pl.stable_rate,
                                rsp_if.out_stable_rate);
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        t_key     ones_key;
        t_key     flip_key;
        t_key     preset_key;
        t_payload ones_pl;
        t_payload mixed_pl;

        req_if.valid                  = 1'b0;
        req_if.opcode                 = OP_UPSERT;
        req_if.in_time_volume         = '0;
        req_if.in_target_pulses       = '0;
        req_if.in_reject_dur_mode_res = '0;
        req_if.in_preset              = '0;
        req_if.in_rate_bits           = '0;
        req_if.in_scheme_id           = '0;
        req_if.in_scheme_revision     = '0;
        req_if.in_startup_pulses      = '0;
        req_if.in_startup_volume      = '0;
        req_if.in_stable_rate         = '0;
        rsp_if.ready                  = 1'b0;

        ones_key   = '1;
        ones_pl    = '1;
        mixed_pl   = {6{32'hA5A5_5A5A}};
        preset_key = ones_key;
        preset_key.preset = 8'hFE;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (phase == 0) begin
                // Empty table, all-zero and all-one keys, replace, near misses
                pending_ops.push_back(make_op(OP_FIND, '0, '0));
                pending_ops.push_back(make_op(OP_UPSERT, '0, '0));
                pending_ops.push_back(make_op(OP_UPSERT, ones_key, ones_pl));
                pending_ops.push_back(make_op(OP_FIND, ones_key, random_payload()));
                pending_ops.push_back(make_op(OP_FIND, '0, ones_pl));
                pending_ops.push_back(make_op(OP_UPSERT, ones_key, mixed_pl));
                pending_ops.push_back(make_op(OP_FIND, ones_key, '0));
                flip_key = ones_key;
                flip_key.preset[0] = 1'b0;
                pending_ops.push_back(make_op(OP_FIND, flip_key, '0));
                flip_key = ones_key;
                flip_key.time_volume[63] = 1'b0;
                pending_ops.push_back(make_op(OP_FIND, flip_key, ones_pl));
                pending_ops.push_back(make_op(OP_UPSERT, preset_key, ~mixed_pl));
                pending_ops.push_back(make_op(OP_FIND, preset_key, '0));
                pending_ops.push_back(make_op(OP_UPSERT, '0, random_payload()));
                pending_ops.push_back(make_op(OP_FIND, '0, '0));
                known_keys.push_back('0);
                known_keys.push_back(ones_key);
                known_keys.push_back(preset_key);
            end
            repeat (PHASE_ITEMS) pending_ops.push_back(random_ring_op());
            // Drain before changing the idle pattern
            while (pending_ops.size() != 0 || req_if.valid || due_results.size() != 0)
                @(negedge i_clk);
        end

        repeat (TBL_DEPTH + 8) @(negedge i_clk);
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
